[rtl/serial_port_capture_fifo_unit_defines.svh]
// Assertion macros used by the checker file of the serial port capture unit.
// Depends on nothing; include by bare file name.
`ifndef SERIAL_PORT_CAPTURE_FIFO_UNIT_DEFINES_SVH
`define SERIAL_PORT_CAPTURE_FIFO_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SPCF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("serial port capture check failed");

// Next-cycle implication, disabled during reset.
`define SPCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("serial port capture check failed");

`endif

[rtl/spcf_pkg.sv]
// Types and constants of the serial port capture unit.
// Depends on nothing; used by the interface users, controller, datapath and top level.
package spcf_pkg;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TAKE  = 2'd2;

    localparam logic [15:0] ADDR_DATA = 16'hFF01;
    localparam logic [15:0] ADDR_CTRL = 16'hFF02;

    localparam logic [7:0] CTRL_TRIGGER  = 8'h81;
    localparam logic [7:0] CTRL_KEEP     = 8'h7F;
    localparam logic [7:0] CTRL_ONES     = 8'h7E;
    localparam logic [7:0] OPEN_BUS_INIT = 8'hFF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] address;
        logic [7:0]  write_data;
    } req_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       serial_irq;
        logic       has_byte;
    } rsp_t;

    typedef logic [7:0] cfg_t;

    // Controller to datapath.
    typedef struct packed {
        logic exec;
        logic load_direct;
        logic load_fetch;
        logic cfg_write;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic needs_fetch;
    } status_t;

    typedef enum logic [1:0] {
        ST_ACCEPT = 2'b01,
        ST_FETCH  = 2'b10
    } state_t;

endpackage

[rtl/spcf_chan_if.sv]
// Valid/ready channel carrying one beat of a typed payload.
// Depends on nothing; payload type is set per instance.
interface spcf_chan_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/spcf_ctrl.sv]
// Controller of the serial port capture unit: accept, ring fetch and output handshake.
// Depends on spcf_pkg.
module spcf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  spcf_pkg::status_t status,
    output spcf_pkg::cmd_t    cmd
);
    import spcf_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   accept;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_ACCEPT) && out_free;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.cfg_write   = cfg_valid;
        case (state_reg)
            ST_ACCEPT:
            begin
                if (accept)
                begin
                    cmd.exec = 1'b1;
                    // a take from a non-empty ring waits in ST_FETCH for the registered memory read
                    if (status.needs_fetch)
                        state_next = ST_FETCH;
                    else
                        cmd.load_direct = 1'b1;
                end
            end
            ST_FETCH:
            begin
                if (out_free)
                begin
                    cmd.load_fetch = 1'b1;
                    state_next     = ST_ACCEPT;
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_direct || cmd.load_fetch)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCEPT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/spcf_datapath.sv]
// Datapath of the serial port capture unit: registers, capture ring memory, output register.
// Depends on spcf_pkg.
module spcf_datapath #(
    parameter int FIFO_SLOTS = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  spcf_pkg::cmd_t    cmd,
    input  spcf_pkg::req_t    req,
    input  spcf_pkg::cfg_t    cfg_data,
    output spcf_pkg::status_t status,
    output spcf_pkg::rsp_t    rsp
);
    import spcf_pkg::*;

    localparam int PTR_W = $clog2(FIFO_SLOTS);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_SLOTS - 1);
    localparam logic [PTR_W-1:0] PTR_STEP = PTR_W'(1);

    logic [7:0]       ring_mem [FIFO_SLOTS];
    logic [7:0]       rd_data_reg;
    logic [7:0]       data_reg;
    logic [7:0]       control_reg;
    logic [7:0]       open_bus_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    rsp_t             rsp_reg;

    logic       is_read, is_write, is_take;
    logic       hit_data, hit_ctrl;
    logic       trigger, ring_empty, ring_full, push, pop;
    logic [7:0] read_value;
    rsp_t       direct_rsp;

    assign head_next = (head_reg == PTR_LAST) ? '0 : head_reg + PTR_STEP;
    assign tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + PTR_STEP;

    assign is_read  = req.opcode == OP_READ;
    assign is_write = req.opcode == OP_WRITE;
    assign is_take  = req.opcode == OP_TAKE;
    assign hit_data = req.address == ADDR_DATA;
    assign hit_ctrl = req.address == ADDR_CTRL;

    assign ring_empty = head_reg == tail_reg;
    assign ring_full  = tail_next == head_reg;
    assign trigger    = is_write && hit_ctrl
                        && ((req.write_data & CTRL_TRIGGER) == CTRL_TRIGGER);
    assign push       = trigger && !ring_full;
    assign pop        = is_take && !ring_empty;

    assign status.needs_fetch = pop;

    always_comb
    begin
        if (hit_data)
            read_value = data_reg;
        else if (hit_ctrl)
            read_value = control_reg | CTRL_ONES;
        else
            read_value = open_bus_reg;
    end

    always_comb
    begin
        direct_rsp            = '0;
        direct_rsp.serial_irq = trigger;
        direct_rsp.has_byte   = !ring_empty || push;
        if (is_read)
            direct_rsp.data_out = read_value;
        else if (is_take)
            direct_rsp.data_out = data_reg;
    end

    // Ring storage: one write port at the tail, one registered read port at the head.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && push)
            ring_mem[tail_reg] <= data_reg;
        if (cmd.exec && pop)
            rd_data_reg <= ring_mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg     <= '0;
            control_reg  <= '0;
            open_bus_reg <= OPEN_BUS_INIT;
            head_reg     <= '0;
            tail_reg     <= '0;
        end
        else
        begin
            if (cmd.cfg_write)
                open_bus_reg <= cfg_data;
            if (cmd.exec)
            begin
                if (is_write && hit_data)
                    data_reg <= req.write_data;
                if (is_write && hit_ctrl)
                    control_reg <= trigger ? (req.write_data & CTRL_KEEP) : req.write_data;
                if (push)
                    tail_reg <= tail_next;
                if (pop)
                    head_reg <= head_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_direct)
            rsp_reg <= direct_rsp;
        else if (cmd.load_fetch)
        begin
            rsp_reg.data_out   <= rd_data_reg;
            rsp_reg.serial_irq <= 1'b0;
            rsp_reg.has_byte   <= !ring_empty;
        end
    end

    assign rsp = rsp_reg;

endmodule

[rtl/serial_port_capture_fifo_unit.sv]
// Top level of the serial port capture unit: serial data/control registers with a capture ring.
// Depends on spcf_pkg, spcf_chan_if, spcf_ctrl and spcf_datapath.
//
// Usage:
//   req carries one bus access or take per beat (opcode, address, write_data);
//   rsp returns exactly one beat per request (data_out, serial_irq, has_byte);
//   cfg writes the open-bus byte, always ready; the user must do so only while the unit is idle, not enforced here.
// Response and throughput:
//   reads, writes and takes from an empty ring answer in the cycle after the request
//   beat and a new request may follow in the next cycle (one item per cycle while rsp
//   is not stalled). A take from a non-empty ring answers through the registered read
//   port of the ring memory and the ST_FETCH state, and blocks req while in ST_FETCH.
// Reset:
//   data and control registers and both ring pointers clear; the open-bus byte
//   returns to 0xFF. Ring contents are not cleared; an entry is read only after
//   it was written. Up to FIFO_SLOTS-1 bytes are held.
// Stall:
//   a waiting rsp beat holds; req stays ready only if the output register drains
//   in the same cycle, so back-pressure reaches req directly.
module serial_port_capture_fifo_unit #(
    parameter int FIFO_SLOTS = 256
) (
    input logic         clk,
    input logic         rst_n,
    spcf_chan_if.sink   req,
    spcf_chan_if.source rsp,
    spcf_chan_if.sink   cfg
);
    import spcf_pkg::*;

    cmd_t    cmd;
    status_t status;
    req_t    req_beat;
    rsp_t    rsp_beat;
    cfg_t    cfg_beat;

    assign req_beat    = req.payload;
    assign cfg_beat    = cfg.payload;
    assign rsp.payload = rsp_beat;

    spcf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cfg_valid (cfg.valid),
        .cfg_ready (cfg.ready),
        .status    (status),
        .cmd       (cmd)
    );

    spcf_datapath #(
        .FIFO_SLOTS (FIFO_SLOTS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (req_beat),
        .cfg_data (cfg_beat),
        .status   (status),
        .rsp      (rsp_beat)
    );

endmodule

[rtl/spcf_checker.sv]
// Port-level checks of the serial port capture unit, bound to its top level.
// Depends on spcf_pkg and serial_port_capture_fifo_unit_defines.svh.
`include "serial_port_capture_fifo_unit_defines.svh"

module spcf_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input spcf_pkg::rsp_t rsp_payload
);
    import spcf_pkg::*;

    // a stalled response beat stays up and keeps its payload
    `SPCF_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `SPCF_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp_payload))

    // a trigger either captured a byte or found the ring full: never empty after it
    `SPCF_ASSERT_IMPL(a_irq_has_byte, clk, rst_n, rsp_valid && rsp_payload.serial_irq, rsp_payload.has_byte)

    // the interrupt only comes from a bus write, whose data is zero
    `SPCF_ASSERT_IMPL(a_irq_zero_data, clk, rst_n, rsp_valid && rsp_payload.serial_irq, rsp_payload.data_out == 8'h00)

endmodule

bind serial_port_capture_fifo_unit spcf_checker u_spcf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);
